FILE: src/cpts_pkg.sv
`timescale 1ns / 1ps

package cpts_pkg;

  localparam int TASK_SLOTS = 64;
  localparam int IDX_W      = $clog2(TASK_SLOTS);
  localparam int SLOT_W     = 6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_YIELD = 3'd1,
    ACT_EXIT  = 3'd2,
    ACT_LOAD  = 3'd3,
    ACT_POFF  = 3'd4,
    ACT_PON   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  slot;
    logic [7:0]  load_priority;
    logic [14:0] load_counter;
    logic        load_running;
  } in_word_t;

  typedef struct packed {
    logic [5:0] current_task;
    logic [5:0] previous_task;
    logic       switched;
    logic       none_runnable;
  } out_word_t;

  // one table row per slot
  typedef struct packed {
    logic               valid;
    logic               running;
    logic signed [15:0] counter;
    logic [7:0]         prio;
    logic [7:0]         preempt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = signed'(v[15:0]);
    end
    return r;
  endfunction

  function automatic entry_t reset_entry(input logic is_slot0);
    entry_t e;
    e = '0;
    if (is_slot0) begin
      e.valid   = 1'b1;
      e.running = 1'b1;
      e.prio    = 8'd1;
    end
    return e;
  endfunction

  function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] t;
    t = {{SLOT_W{1'b0}}, idx};
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot_to_idx(input logic [SLOT_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] t;
    t = {{IDX_W{1'b0}}, s};
    return t[IDX_W-1:0];
  endfunction

endpackage

FILE: src/counter_priority_task_scheduler.sv
`timescale 1ns / 1ps
// Epoch-counter task scheduler over a table of TASK_SLOTS slots.
// Input channel (in_valid_i / in_stall_o) takes one action word at a time:
// tick, yield, exit, load slot, preempt off, preempt on. Every word gives
// exactly one result word on the output channel (out_valid_o / out_stall_i):
// current and previous slot, a switch flag and a none-runnable flag.
// The slot table sits in one RAM, one row per slot, read-modify-write.
// Load and unknown actions go straight to the result; preempt off/on and a
// tick that does not reschedule update the current row. Rescheduling actions
// scan the RAM read port linearly, one slot per cycle, with a second scan as
// a recharge round when the best runnable counter is zero.
// One word is in work at a time; in_stall_o is high until its result is
// handed to the output register. A stalled result holds in that register
// while the next word is taken and worked on.
// Reset: slot 0 valid and running with priority 1, all else zero, current
// slot 0. Per-slot written flags clear at once, so no clearing pass runs.

module counter_priority_task_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cpts_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cpts_pkg::out_word_t out_word_o
);

  cpts_pkg::state_e state_q, state_d;

  logic [2:0]                     act_q, act_d;
  logic [cpts_pkg::IDX_W-1:0]     cur_q, cur_d;
  logic [cpts_pkg::IDX_W-1:0]     prev_q, prev_d;
  logic                           none_q, none_d;
  logic [cpts_pkg::IDX_W-1:0]     idx_q, idx_d;
  logic                           iss_q, iss_d;
  logic                           pass_q, pass_d;
  logic signed [15:0]             best_q, best_d;
  logic [cpts_pkg::IDX_W-1:0]     pick_q, pick_d;
  logic                           rd_vld_q;
  logic [cpts_pkg::IDX_W-1:0]     rd_addr_q;
  logic                           rd_init_q;
  logic [cpts_pkg::TASK_SLOTS-1:0] init_q;
  logic                           out_valid_q, out_valid_d;
  cpts_pkg::out_word_t            out_q, out_d;

  logic                           ram_we, ram_re;
  logic [cpts_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
  cpts_pkg::entry_t               ram_wdata;
  logic [cpts_pkg::ENTRY_W-1:0]   ram_rdata;
  cpts_pkg::entry_t               entry_rd;

  logic in_acc;

  cpts_ram #(
    .WIDTH (cpts_pkg::ENTRY_W),
    .DEPTH (cpts_pkg::TASK_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // rows never written read as their reset value
  assign entry_rd = rd_init_q ? cpts_pkg::entry_t'(ram_rdata)
                              : cpts_pkg::reset_entry(rd_addr_q == '0);

  assign in_stall_o  = (state_q != cpts_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    cpts_pkg::entry_t   wr;
    logic signed [16:0] t;
    logic signed [15:0] dec;
    logic signed [15:0] cnt;
    logic signed [15:0] best_n;
    logic [cpts_pkg::IDX_W-1:0] pick_n;
    logic               go_pick;
    logic               found;

    state_d     = state_q;
    act_d       = act_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    none_d      = none_q;
    idx_d       = idx_q;
    iss_d       = iss_q;
    pass_d      = pass_q;
    best_d      = best_q;
    pick_d      = pick_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    ram_re    = 1'b0;
    ram_raddr = cur_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = entry_rd;

    wr      = entry_rd;
    t       = '0;
    dec     = '0;
    cnt     = entry_rd.counter;
    best_n  = best_q;
    pick_n  = pick_q;
    go_pick = 1'b0;
    found   = 1'b0;

    case (state_q)
      cpts_pkg::ST_IDLE: begin
        if (in_acc) begin
          act_d  = in_word_i.action;
          prev_d = cur_q;
          none_d = 1'b0;
          case (in_word_i.action)
            cpts_pkg::ACT_TICK, cpts_pkg::ACT_YIELD, cpts_pkg::ACT_EXIT,
            cpts_pkg::ACT_POFF, cpts_pkg::ACT_PON: begin
              ram_re    = 1'b1;
              ram_raddr = cur_q;
              state_d   = cpts_pkg::ST_RD;
            end
            cpts_pkg::ACT_LOAD: begin
              if (int'(in_word_i.slot) < cpts_pkg::TASK_SLOTS) begin
                ram_we            = 1'b1;
                ram_waddr         = cpts_pkg::slot_to_idx(in_word_i.slot);
                ram_wdata.valid   = 1'b1;
                ram_wdata.running = in_word_i.load_running;
                ram_wdata.counter = signed'({1'b0, in_word_i.load_counter});
                ram_wdata.prio    = in_word_i.load_priority;
                ram_wdata.preempt = 8'd0;
              end
              state_d = cpts_pkg::ST_FIN;
            end
            default: begin
              state_d = cpts_pkg::ST_FIN;
            end
          endcase
        end
      end

      cpts_pkg::ST_RD: begin
        case (act_q)
          cpts_pkg::ACT_TICK: begin
            t   = {entry_rd.counter[15], entry_rd.counter};
            t   = t - 17'sd1;
            dec = cpts_pkg::sat16(t);
            if (dec > 16'sd0 || entry_rd.preempt != 8'd0) begin
              wr.counter = dec;
            end else begin
              wr.counter = 16'sd0;
              go_pick    = 1'b1;
            end
          end
          cpts_pkg::ACT_YIELD: begin
            wr.counter = 16'sd0;
            go_pick    = 1'b1;
          end
          cpts_pkg::ACT_EXIT: begin
            wr.running = 1'b0;
            wr.counter = 16'sd0;
            go_pick    = 1'b1;
          end
          cpts_pkg::ACT_POFF: begin
            if (entry_rd.preempt != 8'hFF) begin
              wr.preempt = entry_rd.preempt + 8'd1;
            end
          end
          cpts_pkg::ACT_PON: begin
            if (entry_rd.preempt != 8'd0) begin
              wr.preempt = entry_rd.preempt - 8'd1;
            end
          end
          default: begin
          end
        endcase
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = wr;
        if (go_pick) begin
          idx_d   = '0;
          iss_d   = 1'b1;
          pass_d  = 1'b0;
          best_d  = -16'sd1;
          pick_d  = '0;
          state_d = cpts_pkg::ST_SCAN;
        end else begin
          state_d = cpts_pkg::ST_FIN;
        end
      end

      cpts_pkg::ST_SCAN: begin
        if (iss_q) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q;
          if (idx_q == cpts_pkg::LAST_IDX) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (rd_vld_q) begin
          // recharge pass rewrites each valid row in the cycle after its read
          if (pass_q && entry_rd.valid) begin
            t = {{2{entry_rd.counter[15]}}, entry_rd.counter[15:1]}
                + {9'd0, entry_rd.prio};
            cnt = cpts_pkg::sat16(t);
            wr.counter = cnt;
            ram_we     = 1'b1;
            ram_waddr  = rd_addr_q;
            ram_wdata  = wr;
          end
          if (entry_rd.valid && entry_rd.running && cnt > best_q) begin
            best_n = cnt;
            pick_n = rd_addr_q;
          end
          best_d = best_n;
          pick_d = pick_n;
          if (rd_addr_q == cpts_pkg::LAST_IDX) begin
            found = !best_n[15];
            if (!pass_q && found && best_n == 16'sd0) begin
              pass_d = 1'b1;
              idx_d  = '0;
              iss_d  = 1'b1;
              best_d = -16'sd1;
              pick_d = '0;
            end else begin
              cur_d   = found ? pick_n : '0;
              none_d  = !found;
              state_d = cpts_pkg::ST_FIN;
            end
          end
        end
      end

      cpts_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d         = 1'b1;
          out_d.current_task  = cpts_pkg::idx_to_slot(cur_q);
          out_d.previous_task = cpts_pkg::idx_to_slot(prev_q);
          out_d.switched      = (cur_q != prev_q);
          out_d.none_runnable = none_q;
          state_d             = cpts_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = cpts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      iss_q       <= 1'b0;
      pass_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      init_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      iss_q       <= iss_d;
      pass_q      <= pass_d;
      rd_vld_q    <= ram_re;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        init_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    prev_q <= prev_d;
    none_q <= none_d;
    idx_q  <= idx_d;
    best_q <= best_d;
    pick_q <= pick_d;
    out_q  <= out_d;
    if (ram_re) begin
      rd_addr_q <= ram_raddr;
      rd_init_q <= init_q[ram_raddr];
    end
  end

endmodule

FILE: src/cpts_ram.sv
`timescale 1ns / 1ps

module cpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/cpts_checker.sv
`timescale 1ns / 1ps

module cpts_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input cpts_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input cpts_pkg::out_word_t out_word_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after accept");

  a_switch_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_word_o.switched == (out_word_o.current_task != out_word_o.previous_task))
    else $error("switched flag disagrees with task fields");

  a_none_slot0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.none_runnable |-> out_word_o.current_task == '0)
    else $error("none runnable but slot 0 not chosen");

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (.*);
